>>> hw/rtl/rational_arithmetic_unit_macros.svh
// assertion macros shared by the rational arithmetic unit modules
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define RAU_ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("rau: invariant violated");
`define RAU_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rau: implication violated");
`else
`define RAU_ASSERT_ALWAYS(label, clk, rst, expr)
`define RAU_ASSERT_IMPL(label, clk, rst, ante, cons)
`endif

`endif

>>> hw/rtl/rau_pkg.sv
// types and constants of the rational arithmetic unit
`default_nettype none

package rau_pkg;

  localparam int REQ_W     = 4;
  localparam int FIELD_W   = 32;
  localparam int RES_NUM_W = 64;
  localparam int RES_DEN_W = 63;
  localparam int STATUS_W  = 2;

  typedef logic [REQ_W-1:0] req_op_t;

  localparam req_op_t OP_ADD  = 4'd0;
  localparam req_op_t OP_SUB  = 4'd1;
  localparam req_op_t OP_MUL  = 4'd2;
  localparam req_op_t OP_DIV  = 4'd3;
  localparam req_op_t OP_NEG  = 4'd4;
  localparam req_op_t OP_INC  = 4'd5;
  localparam req_op_t OP_DEC  = 4'd6;
  localparam req_op_t OP_LT   = 4'd7;
  localparam req_op_t OP_GT   = 4'd8;
  localparam req_op_t OP_LE   = 4'd9;
  localparam req_op_t OP_GE   = 4'd10;
  localparam req_op_t OP_EQ   = 4'd11;
  localparam req_op_t OP_NE   = 4'd12;
  localparam req_op_t OP_NORM = 4'd13;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_ZERO_DEN = 2'd1;
  localparam status_t ST_OVERFLOW = 2'd2;

  typedef logic [2:0] reg_idx_t;

  localparam reg_idx_t R_AN = 3'd0;
  localparam reg_idx_t R_AD = 3'd1;
  localparam reg_idx_t R_BN = 3'd2;
  localparam reg_idx_t R_BD = 3'd3;
  localparam reg_idx_t R_X  = 3'd4;
  localparam reg_idx_t R_Y  = 3'd5;
  localparam reg_idx_t R_RN = 3'd6;
  localparam reg_idx_t R_RD = 3'd7;

  typedef logic [3:0] cmd_op_t;

  localparam cmd_op_t CMD_NOP     = 4'd0;
  localparam cmd_op_t CMD_LOAD    = 4'd1;
  localparam cmd_op_t CMD_GCD     = 4'd2;
  localparam cmd_op_t CMD_DIV     = 4'd3;
  localparam cmd_op_t CMD_MUL     = 4'd4;
  localparam cmd_op_t CMD_ADD     = 4'd5;
  localparam cmd_op_t CMD_MOVA    = 4'd6;
  localparam cmd_op_t CMD_RNEG_NA = 4'd7;
  localparam cmd_op_t CMD_RNEG_X  = 4'd8;
  localparam cmd_op_t CMD_NEGB    = 4'd9;
  localparam cmd_op_t CMD_ONEB_P  = 4'd10;
  localparam cmd_op_t CMD_ONEB_N  = 4'd11;
  localparam cmd_op_t CMD_SWAPB   = 4'd12;
  localparam cmd_op_t CMD_OUT_ERR = 4'd13;
  localparam cmd_op_t CMD_OUT_CMP = 4'd14;
  localparam cmd_op_t CMD_OUT_ARI = 4'd15;

  typedef struct packed {
    cmd_op_t  op;
    reg_idx_t sa;
    reg_idx_t sb;
    reg_idx_t dst;
  } cmd_t;

  typedef struct packed {
    logic    busy;
    logic    zda;
    logic    zdb;
    logic    zbn;
    logic    out_free;
    req_op_t op;
  } stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/rau_if.sv
// request and result channel interfaces
`default_nettype none

interface rau_req_if import rau_pkg::*;;
  logic                        valid;
  logic                        ready;
  logic [REQ_W-1:0]            req_type;
  logic signed [FIELD_W-1:0]   num_a;
  logic signed [FIELD_W-1:0]   den_a;
  logic signed [FIELD_W-1:0]   num_b;
  logic signed [FIELD_W-1:0]   den_b;

  modport source (output valid, req_type, num_a, den_a, num_b, den_b, input ready);
  modport sink (input valid, req_type, num_a, den_a, num_b, den_b, output ready);
endinterface

interface rau_res_if import rau_pkg::*;;
  logic                        valid;
  logic                        ready;
  logic signed [RES_NUM_W-1:0] res_num;
  logic [RES_DEN_W-1:0]        res_den;
  logic                        compare_true;
  logic [STATUS_W-1:0]         status;

  modport source (output valid, res_num, res_den, compare_true, status, input ready);
  modport sink (input valid, res_num, res_den, compare_true, status, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/rau_datapath.sv
// datapath: operand registers, binary gcd unit, divider, multiplier, result register
`default_nettype none
`include "rational_arithmetic_unit_macros.svh"

module rau_datapath import rau_pkg::*; #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  cmd_t                        cmd,
  output stat_t                       stat,
  input  logic [REQ_W-1:0]            req_type,
  input  logic signed [FIELD_W-1:0]   num_a,
  input  logic signed [FIELD_W-1:0]   den_a,
  input  logic signed [FIELD_W-1:0]   num_b,
  input  logic signed [FIELD_W-1:0]   den_b,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic signed [RES_NUM_W-1:0] out_num,
  output logic [RES_DEN_W-1:0]        out_den,
  output logic                        out_cmp,
  output logic [STATUS_W-1:0]         out_status
);

  localparam int W   = OPERAND_WIDTH;
  localparam int MW  = 2 * W;
  localparam int KW  = $clog2(MW + 1);
  localparam int GKW = $clog2(MW);

  function automatic logic [W-1:0] mag_of(input logic [FIELD_W-1:0] raw);
    logic [W-1:0] v;
    v = raw[W-1:0];
    return v[W-1] ? (~v + 1'b1) : v;
  endfunction

  logic [MW-1:0] an, ad, bn, bd, x, y, rn, rd;
  logic          a_neg, b_neg, r_neg;
  req_op_t       op_q;

  logic [MW-1:0] src_a, src_b;

  logic [MW-1:0] gu, gv, g;
  logic [GKW-1:0] gk;
  logic          g_busy;
  logic [MW-1:0] gu_next, gv_next, g_res;
  logic [GKW-1:0] gk_next;
  logic          g_done;

  logic [MW-1:0] dq, drem;
  logic [KW-1:0] dcnt;
  logic          d_busy;
  reg_idx_t      d_dst;
  logic [MW:0]   d_trial;
  logic          d_ge;
  logic [MW-1:0] drem_next, dq_next;
  logic          d_last;

  logic [MW-1:0] prod;
  logic [MW-1:0] sum;
  logic          sum_neg;

  logic          wr_en;
  reg_idx_t      wr_idx;
  logic [MW-1:0] wr_data;

  logic          l_neg, r_neg_c, c_lt, c_eq, f_eq, cmp_res;
  logic          fin_neg, ovf;
  logic [RES_NUM_W-1:0] rn64;

  // operand select
  always_comb begin
    unique case (cmd.sa)
      R_AN:    src_a = an;
      R_AD:    src_a = ad;
      R_BN:    src_a = bn;
      R_BD:    src_a = bd;
      R_X:     src_a = x;
      R_Y:     src_a = y;
      R_RN:    src_a = rn;
      R_RD:    src_a = rd;
      default: src_a = '0;
    endcase
    unique case (cmd.sb)
      R_AN:    src_b = an;
      R_AD:    src_b = ad;
      R_BN:    src_b = bn;
      R_BD:    src_b = bd;
      R_X:     src_b = x;
      R_Y:     src_b = y;
      R_RN:    src_b = rn;
      R_RD:    src_b = rd;
      default: src_b = '0;
    endcase
  end

  // binary gcd, one step a cycle
  always_comb begin
    gu_next = gu;
    gv_next = gv;
    gk_next = gk;
    g_done  = 1'b0;
    g_res   = '0;
    if (gu == '0) begin
      g_done = 1'b1;
      g_res  = gv << gk;
    end else if (gv == '0) begin
      g_done = 1'b1;
      g_res  = gu << gk;
    end else if (!gu[0] && !gv[0]) begin
      gu_next = gu >> 1;
      gv_next = gv >> 1;
      gk_next = gk + 1'b1;
    end else if (!gu[0]) begin
      gu_next = gu >> 1;
    end else if (!gv[0]) begin
      gv_next = gv >> 1;
    end else if (gu >= gv) begin
      gu_next = (gu - gv) >> 1;
    end else begin
      gv_next = (gv - gu) >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      g_busy <= 1'b0;
    end else if (cmd.op == CMD_GCD) begin
      g_busy <= 1'b1;
    end else if (g_busy && g_done) begin
      g_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == CMD_GCD) begin
      gu <= src_a;
      gv <= src_b;
      gk <= '0;
    end else if (g_busy) begin
      gu <= gu_next;
      gv <= gv_next;
      gk <= gk_next;
      if (g_done) begin
        g <= g_res;
      end
    end
  end

  // restoring divider by the gcd, one quotient bit a cycle
  always_comb begin
    d_trial   = {drem, dq[MW-1]};
    d_ge      = d_trial >= {1'b0, g};
    drem_next = d_ge ? MW'(d_trial - {1'b0, g}) : d_trial[MW-1:0];
    dq_next   = {dq[MW-2:0], d_ge};
    d_last    = d_busy && (dcnt == KW'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_busy <= 1'b0;
    end else if (cmd.op == CMD_DIV) begin
      d_busy <= 1'b1;
    end else if (d_last) begin
      d_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == CMD_DIV) begin
      dq    <= src_a;
      drem  <= '0;
      dcnt  <= KW'(MW);
      d_dst <= cmd.dst;
    end else if (d_busy) begin
      dq   <= dq_next;
      drem <= drem_next;
      dcnt <= dcnt - 1'b1;
    end
  end

  // multiplier and signed-magnitude adder
  assign prod = src_a[W-1:0] * src_b[W-1:0];

  always_comb begin
    if (a_neg == b_neg) begin
      sum     = x + y;
      sum_neg = a_neg;
    end else if (x >= y) begin
      sum     = x - y;
      sum_neg = a_neg;
    end else begin
      sum     = y - x;
      sum_neg = b_neg;
    end
  end

  // register write port
  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = cmd.dst;
    wr_data = prod;
    if (d_last) begin
      wr_en   = 1'b1;
      wr_idx  = d_dst;
      wr_data = dq_next;
    end else if (cmd.op == CMD_MUL) begin
      wr_en   = 1'b1;
    end else if (cmd.op == CMD_ADD) begin
      wr_en   = 1'b1;
      wr_idx  = R_RN;
      wr_data = sum;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      CMD_LOAD: begin
        an    <= MW'(mag_of(num_a));
        ad    <= MW'(mag_of(den_a));
        bn    <= MW'(mag_of(num_b));
        bd    <= MW'(mag_of(den_b));
        a_neg <= (num_a[W-1] ^ den_a[W-1]) && (num_a[W-1:0] != '0);
        b_neg <= (num_b[W-1] ^ den_b[W-1]) && (num_b[W-1:0] != '0);
        op_q  <= req_type;
      end
      CMD_ADD:     r_neg <= sum_neg;
      CMD_MOVA: begin
        rn    <= an;
        rd    <= ad;
        r_neg <= a_neg;
      end
      CMD_RNEG_NA: r_neg <= !a_neg;
      CMD_RNEG_X:  r_neg <= a_neg ^ b_neg;
      CMD_NEGB:    b_neg <= !b_neg && (bn != '0);
      CMD_ONEB_P, CMD_ONEB_N: begin
        bn    <= MW'(1);
        bd    <= MW'(1);
        b_neg <= (cmd.op == CMD_ONEB_N);
      end
      CMD_SWAPB: begin
        bn <= bd;
        bd <= bn;
      end
      default: ;
    endcase
    if (wr_en) begin
      unique case (wr_idx)
        R_AN:    an <= wr_data;
        R_AD:    ad <= wr_data;
        R_BN:    bn <= wr_data;
        R_BD:    bd <= wr_data;
        R_X:     x  <= wr_data;
        R_Y:     y  <= wr_data;
        R_RN:    rn <= wr_data;
        R_RD:    rd <= wr_data;
        default: ;
      endcase
    end
  end

  // comparison of cross products
  always_comb begin
    l_neg   = a_neg && (x != '0);
    r_neg_c = b_neg && (y != '0);
    c_eq    = 1'b0;
    if (l_neg != r_neg_c) begin
      c_lt = l_neg;
    end else if (x == y) begin
      c_lt = 1'b0;
      c_eq = 1'b1;
    end else if (l_neg) begin
      c_lt = x > y;
    end else begin
      c_lt = x < y;
    end
    f_eq = (a_neg == b_neg) && (an == bn) && (ad == bd);
    case (op_q)
      OP_LT:   cmp_res = c_lt;
      OP_GT:   cmp_res = !c_lt && !c_eq;
      OP_LE:   cmp_res = c_lt || c_eq;
      OP_GE:   cmp_res = !c_lt;
      OP_EQ:   cmp_res = f_eq;
      OP_NE:   cmp_res = !f_eq;
      default: cmp_res = 1'b0;
    endcase
  end

  // final sign and range check
  always_comb begin
    fin_neg = r_neg && (rn != '0);
    rn64    = RES_NUM_W'(rn);
    ovf     = 1'b0;
    if (MW >= RES_NUM_W) begin
      ovf = rd[MW-1] || (rn[MW-1] && !(fin_neg && (rn[MW-2:0] == '0)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == CMD_OUT_ERR || cmd.op == CMD_OUT_CMP || cmd.op == CMD_OUT_ARI) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      CMD_OUT_ERR: begin
        out_num    <= '0;
        out_den    <= '0;
        out_cmp    <= 1'b0;
        out_status <= ST_ZERO_DEN;
      end
      CMD_OUT_CMP: begin
        out_num    <= '0;
        out_den    <= RES_DEN_W'(1);
        out_cmp    <= cmp_res;
        out_status <= ST_OK;
      end
      CMD_OUT_ARI: begin
        out_cmp <= 1'b0;
        if (ovf) begin
          out_num    <= '0;
          out_den    <= '0;
          out_status <= ST_OVERFLOW;
        end else begin
          out_num    <= fin_neg ? -rn64 : rn64;
          out_den    <= RES_DEN_W'(rd);
          out_status <= ST_OK;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    stat.busy     = g_busy || d_busy;
    stat.zda      = (ad == '0);
    stat.zdb      = (bd == '0);
    stat.zbn      = (bn == '0);
    stat.out_free = !out_valid || out_ready;
    stat.op       = op_q;
  end

  `RAU_ASSERT_ALWAYS(a_units_exclusive, clk, rst, !(g_busy && d_busy))
  `RAU_ASSERT_IMPL(a_gcd_nonzero, clk, rst, $fell(g_busy), g != '0)
  `RAU_ASSERT_IMPL(a_ok_den_nonzero, clk, rst, out_valid && out_status == ST_OK, out_den != '0)

endmodule

`default_nettype wire

>>> hw/rtl/rau_ctrl.sv
// controller: sequences load, reductions, products and result write per request
`default_nettype none
`include "rational_arithmetic_unit_macros.svh"

module rau_ctrl import rau_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output cmd_t  cmd,
  input  stat_t stat
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;

  localparam logic [5:0] P_CHK  = 6'd1;
  localparam logic [5:0] P_RA0  = 6'd2;
  localparam logic [5:0] P_RA1  = 6'd3;
  localparam logic [5:0] P_RA2  = 6'd4;
  localparam logic [5:0] P_RB0  = 6'd5;
  localparam logic [5:0] P_RB1  = 6'd6;
  localparam logic [5:0] P_RB2  = 6'd7;
  localparam logic [5:0] P_C0   = 6'd8;
  localparam logic [5:0] P_C1   = 6'd9;
  localparam logic [5:0] P_SUB  = 6'd10;
  localparam logic [5:0] P_ONE  = 6'd11;
  localparam logic [5:0] P_AD0  = 6'd12;
  localparam logic [5:0] P_AD1  = 6'd13;
  localparam logic [5:0] P_AD2  = 6'd14;
  localparam logic [5:0] P_AD3  = 6'd15;
  localparam logic [5:0] P_AD4  = 6'd16;
  localparam logic [5:0] P_AD5  = 6'd17;
  localparam logic [5:0] P_AD6  = 6'd18;
  localparam logic [5:0] P_DZ   = 6'd19;
  localparam logic [5:0] P_SW   = 6'd20;
  localparam logic [5:0] P_M0   = 6'd21;
  localparam logic [5:0] P_M1   = 6'd22;
  localparam logic [5:0] P_M2   = 6'd23;
  localparam logic [5:0] P_M3   = 6'd24;
  localparam logic [5:0] P_M4   = 6'd25;
  localparam logic [5:0] P_M5   = 6'd26;
  localparam logic [5:0] P_M6   = 6'd27;
  localparam logic [5:0] P_M7   = 6'd28;
  localparam logic [5:0] P_M8   = 6'd29;
  localparam logic [5:0] P_NEG  = 6'd30;
  localparam logic [5:0] P_NG1  = 6'd31;
  localparam logic [5:0] P_F0   = 6'd32;
  localparam logic [5:0] P_F1   = 6'd33;
  localparam logic [5:0] P_F2   = 6'd34;
  localparam logic [5:0] P_OERR = 6'd35;
  localparam logic [5:0] P_OCMP = 6'd36;
  localparam logic [5:0] P_OARI = 6'd37;

  function automatic cmd_t mk(input cmd_op_t o, input reg_idx_t a, input reg_idx_t b,
                              input reg_idx_t d);
    cmd_t c;
    c.op  = o;
    c.sa  = a;
    c.sb  = b;
    c.dst = d;
    return c;
  endfunction

  logic [1:0] state;
  logic [5:0] pc;
  logic [5:0] pc_next;
  cmd_t       prog;
  logic       accept, binary, is_cmp, is_out;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign binary   = (stat.op <= OP_DIV) || ((stat.op >= OP_LT) && (stat.op <= OP_NE));
  assign is_cmp   = (stat.op >= OP_LT) && (stat.op <= OP_NE);
  assign is_out   = (pc == P_OERR) || (pc == P_OCMP) || (pc == P_OARI);

  always_comb begin
    prog    = mk(CMD_NOP, R_AN, R_AN, R_AN);
    pc_next = P_OERR;
    unique case (pc)
      P_CHK: begin
        pc_next = (stat.op > OP_NORM || stat.zda || (binary && stat.zdb)) ? P_OERR : P_RA0;
      end
      P_RA0: begin prog = mk(CMD_GCD, R_AN, R_AD, R_AN); pc_next = P_RA1; end
      P_RA1: begin prog = mk(CMD_DIV, R_AN, R_AN, R_AN); pc_next = P_RA2; end
      P_RA2: begin
        prog = mk(CMD_DIV, R_AD, R_AD, R_AD);
        if (binary) begin
          pc_next = P_RB0;
        end else if (stat.op == OP_NEG || stat.op == OP_NORM) begin
          pc_next = P_NEG;
        end else begin
          pc_next = P_ONE;
        end
      end
      P_RB0: begin prog = mk(CMD_GCD, R_BN, R_BD, R_BN); pc_next = P_RB1; end
      P_RB1: begin prog = mk(CMD_DIV, R_BN, R_BN, R_BN); pc_next = P_RB2; end
      P_RB2: begin
        prog = mk(CMD_DIV, R_BD, R_BD, R_BD);
        if (is_cmp) begin
          pc_next = P_C0;
        end else if (stat.op == OP_ADD) begin
          pc_next = P_AD0;
        end else if (stat.op == OP_SUB) begin
          pc_next = P_SUB;
        end else if (stat.op == OP_MUL) begin
          pc_next = P_M0;
        end else begin
          pc_next = P_DZ;
        end
      end
      P_C0:  begin prog = mk(CMD_MUL, R_AN, R_BD, R_X); pc_next = P_C1; end
      P_C1:  begin prog = mk(CMD_MUL, R_BN, R_AD, R_Y); pc_next = P_OCMP; end
      P_SUB: begin prog = mk(CMD_NEGB, R_AN, R_AN, R_AN); pc_next = P_AD0; end
      P_ONE: begin
        prog = mk((stat.op == OP_DEC) ? CMD_ONEB_N : CMD_ONEB_P, R_AN, R_AN, R_AN);
        pc_next = P_AD0;
      end
      P_AD0: begin prog = mk(CMD_GCD, R_AD, R_BD, R_AN); pc_next = P_AD1; end
      P_AD1: begin prog = mk(CMD_DIV, R_BD, R_BD, R_X); pc_next = P_AD2; end
      P_AD2: begin prog = mk(CMD_DIV, R_AD, R_AD, R_Y); pc_next = P_AD3; end
      P_AD3: begin prog = mk(CMD_MUL, R_AD, R_X, R_RD); pc_next = P_AD4; end
      P_AD4: begin prog = mk(CMD_MUL, R_AN, R_X, R_X); pc_next = P_AD5; end
      P_AD5: begin prog = mk(CMD_MUL, R_BN, R_Y, R_Y); pc_next = P_AD6; end
      P_AD6: begin prog = mk(CMD_ADD, R_X, R_Y, R_RN); pc_next = P_F0; end
      P_DZ:  begin pc_next = stat.zbn ? P_OERR : P_SW; end
      P_SW:  begin prog = mk(CMD_SWAPB, R_AN, R_AN, R_AN); pc_next = P_M0; end
      P_M0:  begin prog = mk(CMD_GCD, R_AN, R_BD, R_AN); pc_next = P_M1; end
      P_M1:  begin prog = mk(CMD_DIV, R_AN, R_AN, R_AN); pc_next = P_M2; end
      P_M2:  begin prog = mk(CMD_DIV, R_BD, R_BD, R_BD); pc_next = P_M3; end
      P_M3:  begin prog = mk(CMD_GCD, R_BN, R_AD, R_AN); pc_next = P_M4; end
      P_M4:  begin prog = mk(CMD_DIV, R_BN, R_BN, R_BN); pc_next = P_M5; end
      P_M5:  begin prog = mk(CMD_DIV, R_AD, R_AD, R_AD); pc_next = P_M6; end
      P_M6:  begin prog = mk(CMD_MUL, R_AN, R_BN, R_RN); pc_next = P_M7; end
      P_M7:  begin prog = mk(CMD_MUL, R_AD, R_BD, R_RD); pc_next = P_M8; end
      P_M8:  begin prog = mk(CMD_RNEG_X, R_AN, R_AN, R_AN); pc_next = P_F0; end
      P_NEG: begin
        prog = mk(CMD_MOVA, R_AN, R_AN, R_AN);
        pc_next = (stat.op == OP_NEG) ? P_NG1 : P_OARI;
      end
      P_NG1: begin prog = mk(CMD_RNEG_NA, R_AN, R_AN, R_AN); pc_next = P_OARI; end
      P_F0:  begin prog = mk(CMD_GCD, R_RN, R_RD, R_AN); pc_next = P_F1; end
      P_F1:  begin prog = mk(CMD_DIV, R_RN, R_RN, R_RN); pc_next = P_F2; end
      P_F2:  begin prog = mk(CMD_DIV, R_RD, R_RD, R_RD); pc_next = P_OARI; end
      P_OERR: begin prog = mk(CMD_OUT_ERR, R_AN, R_AN, R_AN); pc_next = P_OERR; end
      P_OCMP: begin prog = mk(CMD_OUT_CMP, R_AN, R_AN, R_AN); pc_next = P_OCMP; end
      P_OARI: begin prog = mk(CMD_OUT_ARI, R_AN, R_AN, R_AN); pc_next = P_OARI; end
      default: begin pc_next = P_OERR; end
    endcase
  end

  always_comb begin
    cmd = mk(CMD_NOP, R_AN, R_AN, R_AN);
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd = mk(CMD_LOAD, R_AN, R_AN, R_AN);
        end
      end
      S_RUN: begin
        if (!is_out || stat.out_free) begin
          cmd = prog;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc    <= P_CHK;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_RUN;
            pc    <= P_CHK;
          end
        end
        S_RUN: begin
          if (is_out) begin
            if (stat.out_free) begin
              state <= S_IDLE;
            end
          end else begin
            pc <= pc_next;
            if (prog.op == CMD_GCD || prog.op == CMD_DIV) begin
              state <= S_WAIT;
            end
          end
        end
        S_WAIT: begin
          if (!stat.busy) begin
            state <= S_RUN;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `RAU_ASSERT_IMPL(a_idle_units_quiet, clk, rst, state == S_IDLE, !stat.busy)
  `RAU_ASSERT_IMPL(a_accept_loads, clk, rst, accept, cmd.op == CMD_LOAD)
  `RAU_ASSERT_ALWAYS(a_state_legal, clk, rst, state == S_IDLE || state == S_RUN || state == S_WAIT)

endmodule

`default_nettype wire

>>> hw/rtl/rational_arithmetic_unit.sv
// Rational arithmetic unit: exact fraction arithmetic and comparison with gcd reduction.
//
// req channel: one word carries req_type and two fractions num_a/den_a, num_b/den_b.
// res channel: one word carries res_num/res_den (reduced, positive denominator),
// compare_true and status (ok, zero denominator or divide by zero, overflow).
// One result word per request word, in order.
// A request is taken only while the sequencer is idle; one request is worked at a time.
// Latency is data dependent: each reduction is a binary gcd followed by two divisions
// that each give one quotient bit per cycle.
// Comparisons take two reductions, inc/dec three, add/sub four, mul/div five.
// An error found at the first check skips all reductions; otherwise the time per request
// is set by the shared gcd unit and the shared divider.
// The result sits in an output register; the next request is accepted while it waits.
// A stalled receiver holds the finished word; the following result then waits for it.
// Reset (synchronous, active high) empties the output register and idles the sequencer.

`default_nettype none

module rational_arithmetic_unit import rau_pkg::*; #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  rau_req_if.sink    req,
  rau_res_if.source  res
);

  cmd_t  cmd;
  stat_t stat;

  rau_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  rau_datapath #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .req_type   (req.req_type),
    .num_a      (req.num_a),
    .den_a      (req.den_a),
    .num_b      (req.num_b),
    .den_b      (req.den_b),
    .out_ready  (res.ready),
    .out_valid  (res.valid),
    .out_num    (res.res_num),
    .out_den    (res.res_den),
    .out_cmp    (res.compare_true),
    .out_status (res.status)
  );

endmodule

`default_nettype wire
